FILE: sv/macc_pkg.sv
// Shared types and constants for the HI:LO multiply-accumulate unit.
`default_nettype none

package macc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ACC_W  = 64;

    localparam logic [ACC_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_MAC    = 3'd0,
        OP_MACS   = 3'd1,
        OP_MSAC   = 3'd2,
        OP_MSACS  = 3'd3,
        OP_MACU   = 3'd4,
        OP_MACSU  = 3'd5,
        OP_MSACU  = 3'd6,
        OP_MSACSU = 3'd7
    } t_op;

    typedef struct packed {
        logic rs_signed;
        logic rt_signed;
        logic sub;
        logic sat;
    } t_op_ctl;

    function automatic t_op_ctl decode_op(input t_op op);
        t_op_ctl ctl;
        ctl = '0;
        case (op)
            OP_MAC: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b1, sub: 1'b0, sat: 1'b0};
            end
            OP_MACS: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b1, sub: 1'b0, sat: 1'b1};
            end
            OP_MSAC: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b1, sub: 1'b1, sat: 1'b0};
            end
            OP_MSACS: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b1, sub: 1'b1, sat: 1'b1};
            end
            OP_MACU: begin
                ctl = '{rs_signed: 1'b0, rt_signed: 1'b0, sub: 1'b0, sat: 1'b0};
            end
            OP_MACSU: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b0, sub: 1'b0, sat: 1'b0};
            end
            OP_MSACU: begin
                ctl = '{rs_signed: 1'b0, rt_signed: 1'b0, sub: 1'b1, sat: 1'b0};
            end
            OP_MSACSU: begin
                ctl = '{rs_signed: 1'b1, rt_signed: 1'b0, sub: 1'b1, sat: 1'b0};
            end
            default: begin
                ctl = '0;
            end
        endcase
        return ctl;
    endfunction

endpackage

`default_nettype wire

FILE: sv/multiply_accumulate_hilo.sv
// Top level of the HI:LO multiply-accumulate unit: operand, product and accumulator stages.
//
// Input channel: i_in_valid / o_in_ready carry one word of i_command, i_rs_value and
// i_rt_value. Output channel: o_out_valid / i_out_ready carry the updated accumulator
// as o_acc_hi and o_acc_lo, one result word for every input word, in order.
// Pipeline: operand register, 33x33 signed multiply into a product register, then one
// 64-bit add or subtract with optional signed clamp into the HI:LO accumulator, which
// is itself the output register.
// Path: an accepted word is taken into the operand register, then the product register,
// then the HI:LO accumulator. Throughput: one word per cycle while i_out_ready stays high,
// set by the accumulate loop around the HI:LO register.
// Stall: when the receiver holds i_out_ready low, the result and accumulator hold;
// earlier stages keep filling until each holds a word, then o_in_ready drops.
// Bubbles in the pipeline are squeezed out, so a stalled output does not block
// the input while a stage is empty.
// Reset (i_rst_n low, synchronous): all stages empty, accumulator cleared to zero.
`default_nettype none

module multiply_accumulate_hilo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_rs_value,
    input  wire logic [31:0] i_rt_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_acc_hi,
    output logic [31:0]      o_acc_lo
);

    localparam int unsigned DW = macc_pkg::DATA_W;
    localparam int unsigned AW = macc_pkg::ACC_W;

    // stage enables, each stage loads when it is empty or the one after it can take a word
    logic en1, en2, en3;

    // operand stage
    logic          r_v1;
    macc_pkg::t_op r_op;
    logic [DW-1:0] r_rs;
    logic [DW-1:0] r_rt;

    // product stage
    logic              r_v2;
    macc_pkg::t_op_ctl r_ctl2;
    logic [AW-1:0]     r_prod;

    // accumulator / output stage
    logic          r_v3;
    logic [AW-1:0] r_acc;

    macc_pkg::t_op_ctl  dec_ctl;
    logic signed [DW:0]     mul_a;
    logic signed [DW:0]     mul_b;
    logic signed [2*DW+1:0] mul_p;
    logic [AW-1:0]          n_prod;

    logic [AW-1:0] add_b;
    logic [AW-1:0] sum;
    logic          ovf;
    logic [AW-1:0] n_acc;

    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_comb begin
        dec_ctl = macc_pkg::decode_op(r_op);
        mul_a   = {dec_ctl.rs_signed & r_rs[DW-1], r_rs};
        mul_b   = {dec_ctl.rt_signed & r_rt[DW-1], r_rt};
        mul_p   = mul_a * mul_b;
        n_prod  = mul_p[AW-1:0];
    end

    // subtract as add of the inverted product with carry in
    always_comb begin
        add_b = r_ctl2.sub ? ~r_prod : r_prod;
        sum   = r_acc + add_b + {{(AW-1){1'b0}}, r_ctl2.sub};
        ovf   = r_ctl2.sat && (r_acc[AW-1] == add_b[AW-1]) && (sum[AW-1] != r_acc[AW-1]);
        if (ovf) begin
            n_acc = r_acc[AW-1] ? macc_pkg::SAT_MIN : macc_pkg::SAT_MAX;
        end else begin
            n_acc = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_acc <= '0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
                if (r_v2) begin
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_op <= macc_pkg::t_op'(i_command);
            r_rs <= i_rs_value;
            r_rt <= i_rt_value;
        end
        if (en2 && r_v1) begin
            r_ctl2 <= dec_ctl;
            r_prod <= n_prod;
        end
    end

    assign o_out_valid = r_v3;
    assign o_acc_hi    = r_acc[AW-1:DW];
    assign o_acc_lo    = r_acc[DW-1:0];

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_acc == '0))
        else $error("reset left a result pending or the accumulator nonzero");

    a_acc_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v2 && en3) |=> $stable(r_acc))
        else $error("accumulator moved without a product entering");

    a_bubble_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3) |-> o_in_ready)
        else $error("input stalled while a stage was empty");

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3 && ovf) |=>
            (r_acc == macc_pkg::SAT_MAX || r_acc == macc_pkg::SAT_MIN))
        else $error("saturating overflow did not clamp");

    a_result_follows_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> o_out_valid)
        else $error("product entered but no result shown");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the HI:LO multiply-accumulate unit with random idling and stalls.
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_command;
    logic [31:0] i_rs_value;
    logic [31:0] i_rt_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_acc_hi;
    logic [31:0] o_acc_lo;

    logic [63:0] shadow_acc;
    logic [63:0] expected_acc_q[$];
    logic [63:0] want_acc;
    int          error_count;
    int          hold_cycles;
    bit          send_gaps_on;
    bit          stall_on;

    multiply_accumulate_hilo i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_rs_value  (i_rs_value),
        .i_rt_value  (i_rt_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_acc_hi    (o_acc_hi),
        .o_acc_lo    (o_acc_lo)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Accumulator update for one word: product, add or subtract, optional signed clamp.
    function automatic logic [63:0] next_acc(input macc_pkg::t_op op,
                                             input logic [31:0] rs,
                                             input logic [31:0] rt,
                                             input logic [63:0] acc);
        logic [63:0] rs_s;
        logic [63:0] rt_s;
        logic [63:0] rs_u;
        logic [63:0] rt_u;
        logic [63:0] prod;
        logic [63:0] sum;
        logic        do_sub;
        logic        do_sat;
        logic        ovf;
        rs_s = {{32{rs[31]}}, rs};
        rt_s = {{32{rt[31]}}, rt};
        rs_u = {32'd0, rs};
        rt_u = {32'd0, rt};
        do_sub = 1'b0;
        do_sat = 1'b0;
        case (op)
            macc_pkg::OP_MAC, macc_pkg::OP_MACS,
            macc_pkg::OP_MSAC, macc_pkg::OP_MSACS: begin
                prod = rs_s * rt_s;
            end
            macc_pkg::OP_MACU, macc_pkg::OP_MSACU: begin
                prod = rs_u * rt_u;
            end
            default: begin
                prod = rs_s * rt_u;
            end
        endcase
        case (op)
            macc_pkg::OP_MSAC, macc_pkg::OP_MSACS,
            macc_pkg::OP_MSACU, macc_pkg::OP_MSACSU: begin
                do_sub = 1'b1;
            end
            default: begin
                do_sub = 1'b0;
            end
        endcase
        if (op == macc_pkg::OP_MACS || op == macc_pkg::OP_MSACS) begin
            do_sat = 1'b1;
        end
        sum = do_sub ? acc - prod : acc + prod;
        if (do_sub) begin
            ovf = (acc[63] != prod[63]) && (acc[63] != sum[63]);
        end else begin
            ovf = (acc[63] == prod[63]) && (acc[63] != sum[63]);
        end
        if (do_sat && ovf) begin
            sum = acc[63] ? macc_pkg::SAT_MIN : macc_pkg::SAT_MAX;
        end
        return sum;
    endfunction

    // Offer one word; return at the edge that accepts it.
    task automatic send_word(input macc_pkg::t_op op, input logic [31:0] rs,
                             input logic [31:0] rt);
        @(negedge i_clk);
        while (send_gaps_on && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= op;
        i_rs_value <= rs;
        i_rt_value <= rt;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        shadow_acc = next_acc(op, rs, rt, shadow_acc);
        expected_acc_q.push_back(shadow_acc);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_acc_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Bias operands toward sign and magnitude corners.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 5))
                0: v = 32'h0000_0000;
                1: v = 32'h0000_0001;
                2: v = 32'h7FFF_FFFF;
                3: v = 32'h8000_0000;
                4: v = 32'h8000_0001;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    task automatic send_random_words(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(macc_pkg::t_op'($urandom_range(0, 7)), pick_operand(), pick_operand());
        end
    endtask

    task automatic test_corner_operands();
        send_word(macc_pkg::OP_MAC,    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(macc_pkg::OP_MACS,   32'h8000_0000, 32'hFFFF_FFFF);
        send_word(macc_pkg::OP_MSAC,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(macc_pkg::OP_MSACS,  32'h0000_0000, 32'hFFFF_FFFF);
        send_word(macc_pkg::OP_MACU,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(macc_pkg::OP_MACSU,  32'h8000_0000, 32'hFFFF_FFFF);
        send_word(macc_pkg::OP_MSACU,  32'hFFFF_FFFF, 32'h8000_0000);
        send_word(macc_pkg::OP_MSACSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stop_sending();
    endtask

    task automatic test_saturation();
        // Push to the positive limit, then hold there.
        repeat (5) send_word(macc_pkg::OP_MACS, 32'h8000_0000, 32'h8000_0000);
        // Opposite signs: no clamp.
        send_word(macc_pkg::OP_MACS, 32'hFFFF_FFFF, 32'h0000_0001);
        // Subtract a negative product at the top: clamp high.
        send_word(macc_pkg::OP_MSACS, 32'h8000_0000, 32'h7FFF_FFFF);
        // Walk down past the negative limit and stay there.
        repeat (5) send_word(macc_pkg::OP_MSACS, 32'h8000_0000, 32'h8000_0000);
        send_word(macc_pkg::OP_MACS, 32'h8000_0000, 32'h7FFF_FFFF);
        stop_sending();
    endtask

    task automatic test_random_mix();
        send_random_words(130);
        send_gaps_on = 1'b0;
        stall_on     = 1'b0;
        send_random_words(100);
        send_gaps_on = 1'b1;
        stall_on     = 1'b1;
        send_random_words(130);
        stop_sending();
    endtask

    task automatic test_output_holdoff();
        send_gaps_on = 1'b0;
        hold_cycles  = 60;
        send_random_words(24);
        send_gaps_on = 1'b1;
        stop_sending();
    endtask

    task automatic test_drain_pause();
        send_random_words(10);
        stop_sending();
        drain_results();
        send_random_words(10);
        stop_sending();
    endtask

    // Receiver: long hold-off on request, otherwise random stalls while stall_on is set.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (stall_on && $urandom_range(0, 99) < 15) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_acc_q.size() == 0) begin
                $display("%0t: result word with nothing expected, hi=%h lo=%h",
                         $time, o_acc_hi, o_acc_lo);
                error_count++;
            end else begin
                want_acc = expected_acc_q.pop_front();
                if (o_acc_hi !== want_acc[63:32]) begin
                    $display("%0t: acc_hi expected %h actual %h",
                             $time, want_acc[63:32], o_acc_hi);
                    error_count++;
                end
                if (o_acc_lo !== want_acc[31:0]) begin
                    $display("%0t: acc_lo expected %h actual %h",
                             $time, want_acc[31:0], o_acc_lo);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #200000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_acc_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = macc_pkg::OP_MAC;
        i_rs_value   = '0;
        i_rt_value   = '0;
        i_out_ready  = 1'b0;
        shadow_acc   = '0;
        error_count  = 0;
        hold_cycles  = 0;
        send_gaps_on = 1'b1;
        stall_on     = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_operands();
        test_saturation();
        test_random_mix();
        test_output_holdoff();
        test_drain_pause();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
